@@ hdl/mpf_pkg.sv @@
package mpf_pkg;

   localparam int BYTE_W = 8;
   localparam int POS_W = 32;
   localparam int LEN_W = 7;
   localparam int SYNC_BIT = 3;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_NO_DATA  = 2'd1,
      ST_ZERO_LEN = 2'd2
   } status_type;

endpackage

@@ hdl/mpf_ram.sv @@
module mpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mouse_packet_framer_ring.sv @@
// Mouse packet framer with a byte ring.
// Input beats are taken on start while busy is low. req_op 0 hands in one
// mouse byte: it is dropped unless enable (csr_write_enable/csr_write_data)
// is set, and a packet only starts on a byte with bit 3 set. A byte that
// completes a packet holds busy while the packet is written into the ring
// memory, one byte per cycle; any other mouse byte leaves busy low.
// req_op 1 is a read: req_read_pos/req_read_len. If nothing is available or
// the length is zero, one status beat shows on rsp_* the cycle after accept.
// Otherwise up to min(len, RING_DEPTH) bytes stream out, one per cycle
// through the memory's registered read port, starting at the slot given by
// the position's low bits (RING_DEPTH is a power of two); the S_READ state
// and the memory output register come before each beat; busy holds in S_READ.
// rsp_strobe marks each result for one cycle; rsp_last marks the final one.
// There is no backpressure on the result side.
// Reset (synchronous) clears enable, sync hunt and the write position; the
// ring contents are undefined until written, no clearing pass is run.
module mouse_packet_framer_ring #(
   parameter int RING_DEPTH = 64,
   parameter int PACKET_BYTES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [mpf_pkg::BYTE_W-1:0]    req_mouse_byte,
   input  logic [mpf_pkg::POS_W-1:0]     req_read_pos,
   input  logic [mpf_pkg::LEN_W-1:0]     req_read_len,
   input  logic                          csr_write_enable,
   input  logic                          csr_write_data,
   output logic                          rsp_strobe,
   output logic [mpf_pkg::BYTE_W-1:0]    rsp_data_byte,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_last
);

   import mpf_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int PIW = $clog2(PACKET_BYTES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_COMMIT,
      S_READ
   } state_type;

   state_type               state_ff, state_in;
   logic                    enable_ff, enable_in;
   logic [PIW-1:0]          phase_ff, phase_in;
   logic [POS_W-1:0]        wp_ff, wp_in;
   logic [AW-1:0]           wr_slot_ff, wr_slot_in;
   logic [BYTE_W-1:0]       pend_ff [PACKET_BYTES];
   logic [BYTE_W-1:0]       pend_in [PACKET_BYTES];
   logic [PIW-1:0]          cnt_ff, cnt_in;
   logic [LEN_W-1:0]        left_ff, left_in;
   logic [AW-1:0]           rd_slot_ff, rd_slot_in;
   logic                    rsp_strobe_ff, rsp_strobe_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_ra;
   logic [BYTE_W-1:0]       ram_rd;

   logic [POS_W:0]          diff;
   logic                    no_data;
   logic [LEN_W-1:0]        len_c;
   logic [LEN_W-1:0]        n_bytes;

   mpf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_slot_ff),
      .wr_data (pend_ff[cnt_ff]),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // available count and clamped length for a read request
   always_comb begin
      diff = {1'b0, wp_ff} - {1'b0, req_read_pos};
      no_data = diff[POS_W] | (diff[POS_W-1:0] == '0);
      len_c = (req_read_len > LEN_W'(RING_DEPTH)) ? LEN_W'(RING_DEPTH) : req_read_len;
      if (|diff[POS_W-1:LEN_W]) begin
         n_bytes = len_c;
      end else begin
         n_bytes = (diff[LEN_W-1:0] < len_c) ? diff[LEN_W-1:0] : len_c;
      end
   end

   always_comb begin
      state_in = state_ff;
      enable_in = enable_ff;
      phase_in = phase_ff;
      wp_in = wp_ff;
      wr_slot_in = wr_slot_ff;
      pend_in = pend_ff;
      cnt_in = cnt_ff;
      left_in = left_ff;
      rd_slot_in = rd_slot_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_last_in = 1'b0;
      ram_we = 1'b0;
      ram_ra = rd_slot_ff;

      if (csr_write_enable) begin
         enable_in = csr_write_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (!req_op) begin
                  if (enable_ff) begin
                     if (phase_ff == '0) begin
                        if (req_mouse_byte[SYNC_BIT]) begin
                           pend_in[0] = req_mouse_byte;
                           phase_in = PIW'(1);
                        end
                     end else if (phase_ff != PIW'(PACKET_BYTES - 1)) begin
                        pend_in[phase_ff] = req_mouse_byte;
                        phase_in = phase_ff + PIW'(1);
                     end else begin
                        pend_in[PACKET_BYTES-1] = req_mouse_byte;
                        phase_in = '0;
                        cnt_in = '0;
                        state_in = S_COMMIT;
                     end
                  end
               end else if (no_data) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_NO_DATA;
                  rsp_last_in = 1'b1;
               end else if (req_read_len == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_ZERO_LEN;
                  rsp_last_in = 1'b1;
               end else begin
                  left_in = n_bytes;
                  // stale positions land on the same slot modulo the depth
                  rd_slot_in = req_read_pos[AW-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_COMMIT: begin
            ram_we = 1'b1;
            wr_slot_in = (wr_slot_ff == AW'(RING_DEPTH - 1)) ? '0 : wr_slot_ff + AW'(1);
            cnt_in = cnt_ff + PIW'(1);
            if (cnt_ff == PIW'(PACKET_BYTES - 1)) begin
               wp_in = wp_ff + POS_W'(PACKET_BYTES);
               state_in = S_IDLE;
            end
         end
         S_READ: begin
            // data shows next cycle from the memory's output register
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_DATA;
            rsp_last_in = (left_ff == LEN_W'(1));
            left_in = left_ff - LEN_W'(1);
            rd_slot_in = (rd_slot_ff == AW'(RING_DEPTH - 1)) ? '0 : rd_slot_ff + AW'(1);
            if (left_ff == LEN_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         enable_ff <= 1'b0;
         phase_ff <= '0;
         wp_ff <= '0;
         wr_slot_ff <= '0;
         cnt_ff <= '0;
         left_ff <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_status_ff <= ST_DATA;
         rsp_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         enable_ff <= enable_in;
         phase_ff <= phase_in;
         wp_ff <= wp_in;
         wr_slot_ff <= wr_slot_in;
         cnt_ff <= cnt_in;
         left_ff <= left_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff <= rsp_last_in;
      end
      pend_ff <= pend_in;
      rd_slot_ff <= rd_slot_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_data_byte = (rsp_status_ff == ST_DATA) ? ram_rd : '0;

endmodule
